// ===== rtl/dht_pkg.sv =====
// Shared types, codes and fixed widths of the double-hashed key/data table.
package dht_pkg;

	localparam int KEY_BITS       = 16;
	localparam int VALUE_BITS     = 32;
	localparam int SLOT_BITS      = 4;
	// Hashing computes the quotient first and then the remainder.
	localparam int HASH_STEPS     = 2;
	localparam int HASH_CNT_BITS  = $clog2(HASH_STEPS);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [2:0] RES_INSERTED  = 3'd0;
	localparam logic [2:0] RES_FOUND     = 3'd1;
	localparam logic [2:0] RES_NOT_FOUND = 3'd2;
	localparam logic [2:0] RES_FULL      = 3'd3;
	localparam logic [2:0] RES_DELETED   = 3'd4;

	localparam logic [1:0] ST_EMPTY   = 2'd0;
	localparam logic [1:0] ST_LIVE    = 2'd1;
	localparam logic [1:0] ST_DELETED = 2'd2;

	typedef struct packed {
		logic [1:0]                   command;
		logic [KEY_BITS-1:0]          key;
		logic signed [VALUE_BITS-1:0] value_in;
	} dht_req_t;

	typedef struct packed {
		logic [2:0]                   status;
		logic signed [VALUE_BITS-1:0] value_out;
		logic [SLOT_BITS-1:0]         slot;
	} dht_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic hash;
		logic advance;
		logic finish;
	} dht_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hash_last;
		logic probe_end;
		logic rsp_free;
	} dht_sts_t;

endpackage

// ===== rtl/dht_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module dht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dht_ctrl.sv =====
// Controller state machine that sequences hashing and probing of one request.
module dht_ctrl
	import dht_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dht_sts_t sts,
	output dht_ctl_t ctl
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_HASH  = 2'd1;
	localparam logic [1:0] S_ADDR  = 2'd2;
	localparam logic [1:0] S_CHECK = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				ctl.hash = 1'b1;
				if (sts.hash_last) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.probe_end) begin
					if (sts.rsp_free) begin
						ctl.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					ctl.advance = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

endmodule

// ===== rtl/dht_datapath.sv =====
// Datapath: key hashing, probe position, slot states, entry RAM and response register.
module dht_datapath
	import dht_pkg::*;
#(
	parameter int TABLE_SLOTS = 9
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dht_req_t req,
	input  dht_ctl_t ctl,
	output dht_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output dht_rsp_t rsp
);

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int WW = KEY_BITS + VALUE_BITS;
	localparam int RS = KEY_BITS + IW;
	localparam int RW = KEY_BITS + 2;
	localparam int QW = RW - IW;
	localparam int PW = KEY_BITS + RW;
	localparam logic [RW-1:0] RECIP = RW'(((longint'(1) << RS) + longint'(TABLE_SLOTS) - 1)
		/ longint'(TABLE_SLOTS));
	localparam logic [IW:0]   SLOTS_W = (IW+1)'(TABLE_SLOTS);
	localparam logic [IW-1:0] LAST_W  = IW'(TABLE_SLOTS - 1);
	localparam logic [IW-1:0] STEP0   = IW'(4 % TABLE_SLOTS);
	localparam logic [IW-1:0] STEP1   = IW'(5 % TABLE_SLOTS);

	logic [1:0]               cmd_q;
	logic [KEY_BITS-1:0]      key_q;
	logic [QW-1:0]            quot_q;
	logic [VALUE_BITS-1:0]    val_q;
	logic [IW-1:0]            pos_q;
	logic [IW-1:0]            step_q;
	logic [IW-1:0]            cnt_q;
	logic [HASH_CNT_BITS-1:0] hcnt_q;
	logic [1:0]               st_q [TABLE_SLOTS];
	logic                     rsp_valid_q;
	dht_rsp_t                 rsp_q;

	// Home slot by reciprocal multiplication: the quotient of the key by the
	// slot count is registered first, and the remainder is then taken from
	// it.
	logic [PW-1:0]       prod;
	logic [QW-1:0]       quot_d;
	logic [KEY_BITS-1:0] qmul;
	logic [KEY_BITS-1:0] rem_full;
	logic [IW-1:0]       rem_d;
	logic                hash_last;
	always_comb begin
		prod     = PW'(key_q) * PW'(RECIP);
		quot_d   = prod[PW-1:RS];
		qmul     = KEY_BITS'(quot_q) * KEY_BITS'(TABLE_SLOTS);
		rem_full = key_q - qmul;
		rem_d    = rem_full[IW-1:0];
	end

	assign hash_last = (hcnt_q == HASH_CNT_BITS'(HASH_STEPS - 1));

	logic [IW:0]   pos_sum;
	logic [IW-1:0] pos_next;
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, step_q};
		if (pos_sum >= SLOTS_W) begin
			pos_sum = pos_sum - SLOTS_W;
		end
		pos_next = pos_sum[IW-1:0];
	end

	logic [IW-1:0] raddr;
	logic [WW-1:0] rdata;
	logic          ram_we;
	assign raddr = ctl.advance ? pos_next : pos_q;

	dht_ram #(
		.WIDTH(WW),
		.DEPTH(TABLE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata({key_q, val_q}),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic [KEY_BITS-1:0]   rkey;
	logic [VALUE_BITS-1:0] rval;
	logic [1:0]            cur_st;
	logic                  match;
	logic                  last;
	logic                  probe_end;
	logic                  mark_del;
	dht_rsp_t              res;

	assign rkey   = rdata[WW-1:VALUE_BITS];
	assign rval   = rdata[VALUE_BITS-1:0];
	assign cur_st = st_q[pos_q];
	assign match  = (cur_st == ST_LIVE) && (rkey == key_q);
	assign last   = (cnt_q == LAST_W);

	always_comb begin
		res       = '0;
		probe_end = 1'b1;
		ram_we    = 1'b0;
		mark_del  = 1'b0;
		res.status = RES_NOT_FOUND;
		case (cmd_q)
			CMD_INSERT: begin
				probe_end = (cur_st != ST_LIVE) || last;
				if (cur_st != ST_LIVE) begin
					res.status = RES_INSERTED;
					res.slot   = SLOT_BITS'(pos_q);
					ram_we     = ctl.finish;
				end else begin
					res.status = RES_FULL;
				end
			end
			CMD_SEARCH, CMD_DELETE: begin
				probe_end = (cur_st == ST_EMPTY) || match || last;
				if (match) begin
					res.status    = (cmd_q == CMD_DELETE) ? RES_DELETED : RES_FOUND;
					res.value_out = rval;
					res.slot      = SLOT_BITS'(pos_q);
					mark_del      = ctl.finish && (cmd_q == CMD_DELETE);
				end
			end
			default: begin
				probe_end = 1'b1;
			end
		endcase
	end

	// Request capture, hashing and probe stepping.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= req.command;
			key_q    <= req.key;
			val_q    <= req.value_in;
			pos_q    <= '0;
			step_q   <= req.key[0] ? STEP1 : STEP0;
			cnt_q    <= '0;
			hcnt_q   <= '0;
		end else if (ctl.hash) begin
			if (hash_last) begin
				pos_q <= rem_d;
			end else begin
				quot_q <= quot_d;
			end
			hcnt_q   <= hcnt_q + 1'b1;
		end else if (ctl.advance) begin
			pos_q <= pos_next;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				st_q[i] <= ST_EMPTY;
			end
		end else if (ram_we) begin
			st_q[pos_q] <= ST_LIVE;
		end else if (mark_del) begin
			st_q[pos_q] <= ST_DELETED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= ctl.finish || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			rsp_q <= res;
		end
	end

	assign sts.hash_last = hash_last;
	assign sts.probe_end = probe_end;
	assign sts.rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

// ===== rtl/double_hash_table.sv =====
// Top level of the double-hashed key/data table with tombstone deletion.
//
// This block keeps TABLE_SLOTS key/data entries in an open-addressed table and
// serves one request at a time: insert, search or delete. A key's home slot is
// the key modulo TABLE_SLOTS and its probe step is 4 for even keys and 5 for
// odd keys, so TABLE_SLOTS must share no factor with 4 or 5. Insert takes the
// first empty or deleted slot on the probe sequence without looking for an
// existing copy of the key and answers table full when every slot is live.
// Search and delete skip deleted slots, stop at the first live slot whose key
// matches, and answer not found at an empty slot or after visiting every slot;
// delete turns the matching slot into a tombstone and returns its data. An
// unused command code changes nothing and answers not found. A request is
// accepted, its key is reduced to its home slot (the quotient by a
// reciprocal multiplication, then the remainder), the first entry is read,
// and then one slot is probed per cycle; the last probe waits while the
// output register holds a response not yet taken. The probe loop runs
// through the entry RAM's single read port. A new request is taken once
// the previous one has its response registered, and a response waits in
// the output register while the next request is hashed and probed. The
// slot states reset to empty at once; stored keys and data need no clearing.
module double_hash_table
	import dht_pkg::*;
#(
	parameter int TABLE_SLOTS = 9
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dht_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output dht_rsp_t rsp
);

	// Command and status groups between the controller and the datapath.
	dht_ctl_t ctl;
	dht_sts_t sts;

	// The controller walks each request through hashing and probing.
	dht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// The datapath holds the table and builds the registered response.
	dht_datapath #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ctl      (ctl),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

// ===== bench/double_hash_table_checker.sv =====
// Response checker for the double-hashed key/data table.
module double_hash_table_checker
	import dht_pkg::*;
#(
	parameter int TABLE_SLOTS = 9
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_stall,
	input  dht_req_t req,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  dht_rsp_t rsp,
	output int       failures,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0]                   slot_state [TABLE_SLOTS];
	logic [KEY_BITS-1:0]          slot_key   [TABLE_SLOTS];
	logic signed [VALUE_BITS-1:0] slot_value [TABLE_SLOTS];
	dht_rsp_t                     expected_rsps [$];

	// Carries out one request on the shadow table and returns its response.
	function automatic dht_rsp_t table_lookup(input dht_req_t r);
		dht_rsp_t a;
		int       pos;
		int       step;
		int       hit;
		a.status    = RES_NOT_FOUND;
		a.value_out = '0;
		a.slot      = '0;
		pos  = int'(r.key) % TABLE_SLOTS;
		step = 4 + int'(r.key[0]);
		hit  = -1;
		case (r.command)
			CMD_INSERT: begin
				a.status = RES_FULL;
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (slot_state[pos] != ST_LIVE) begin
						slot_state[pos] = ST_LIVE;
						slot_key[pos]   = r.key;
						slot_value[pos] = r.value_in;
						a.status        = RES_INSERTED;
						a.slot          = SLOT_BITS'(pos);
						break;
					end
					pos = (pos + step) % TABLE_SLOTS;
				end
			end
			CMD_SEARCH, CMD_DELETE: begin
				for (int i = 0; i < TABLE_SLOTS; i++) begin
					if (slot_state[pos] == ST_EMPTY)
						break;
					if (slot_state[pos] == ST_LIVE && slot_key[pos] == r.key) begin
						hit = pos;
						break;
					end
					pos = (pos + step) % TABLE_SLOTS;
				end
				if (hit >= 0) begin
					a.slot      = SLOT_BITS'(hit);
					a.value_out = slot_value[hit];
					if (r.command == CMD_DELETE) begin
						slot_state[hit] = ST_DELETED;
						a.status        = RES_DELETED;
					end else begin
						a.status = RES_FOUND;
					end
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	// Responses are checked before new requests are predicted, so that a
	// response leaving at the same edge is never matched to a fresh request.
	always @(posedge clk or negedge arst_n) begin
		dht_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++)
				slot_state[i] = ST_EMPTY;
			expected_rsps.delete();
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding: %p", rsp);
					failures++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
						failures++;
					end
					if (rsp.value_out !== want.value_out) begin
						$error("value_out mismatch: expected %0d, got %0d",
							want.value_out, rsp.value_out);
						failures++;
					end
					if (rsp.slot !== want.slot) begin
						$error("slot mismatch: expected %0d, got %0d", want.slot, rsp.slot);
						failures++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsps.push_back(table_lookup(req));
			pending = expected_rsps.size();
		end
	end

endmodule

// ===== bench/double_hash_table_tb.sv =====
// Top of the double-hashed table testbench: clock, reset, stimulus and verdict.
module double_hash_table_tb;
	import dht_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS = 9;
	// Number of random requests after the directed part.
	localparam int ITEM_COUNT  = 1050;
	// The last stretch of requests runs with no idling on either side.
	localparam int QUIET_ITEMS = 100;
	// A correct run never goes this long without moving a request or a
	// response: the limit lies well beyond the longest receiver hold-off,
	// LONG_HOLD, and beyond a full probe walk.
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 60;
	localparam int POOL_SIZE   = 16;

	// The fourth command code has no meaning; the block must answer not found.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	dht_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	dht_rsp_t rsp;

	int   failures;
	int   pending;
	int   requests_sent;
	int   quiet_cycles;
	logic quiet     = 1'b0;
	logic held_long = 1'b0;

	// Keys are mostly drawn from a small pool so that inserts, searches and
	// deletes keep meeting each other in the table.
	logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

	always #4 clk = ~clk;

	double_hash_table #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	double_hash_table_checker #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) checker_inst (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.failures (failures),
		.pending  (pending)
	);

	// Presents one request from a falling edge and holds it until the block
	// takes it. Afterwards the sender may go idle for a short burst. When the
	// next request follows at once, valid simply stays high, so it is never
	// lowered and raised within one time step.
	task automatic send_request(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] data);
		dht_req_t r;
		r.command  = op;
		r.key      = key;
		r.value_in = data;
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		requests_sent++;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	// The pool keeps pairs of keys that share a home slot, so probe chains
	// form, and it is refreshed now and then to move through the key space.
	task automatic refill_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i < POOL_SIZE / 2) begin
				key_pool[i] = KEY_BITS'($urandom_range(0, 65535));
			end else begin
				key_pool[i] = KEY_BITS'(int'(key_pool[i - POOL_SIZE / 2]) % TABLE_SLOTS
					+ TABLE_SLOTS * $urandom_range(0, 7000));
			end
		end
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return KEY_BITS'($urandom_range(0, 65535));
		return key_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// Main stimulus: reset, a directed walk through the special cases, then
	// random traffic that alternates between filling and draining the table.
	initial begin
		int               pick;
		logic [1:0]       op;
		logic [KEY_BITS-1:0] fill_keys [6];
		refill_pool();
		fill_keys = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd7, 16'd10};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Extremes of key and data: key 0 lands in slot 0, key 0xFFFF in slot 6.
		send_request(CMD_INSERT, 16'h0000, 32'h7FFF_FFFF);
		send_request(CMD_INSERT, 16'hFFFF, 32'h8000_0000);
		send_request(CMD_SEARCH, 16'h0000, 32'h0);
		send_request(CMD_SEARCH, 16'hFFFF, 32'hFFFF_FFFF);
		// Key 9 shares home slot 0 with key 0 and misses at the empty slot 5.
		send_request(CMD_SEARCH, 16'd9, 32'h0);
		// Two copies of key 9: no duplicate check, the second goes to slot 1.
		send_request(CMD_INSERT, 16'd9, 32'd1);
		send_request(CMD_INSERT, 16'd9, 32'd2);
		// Deleting leaves a tombstone in slot 5 that the next search skips.
		send_request(CMD_DELETE, 16'd9, 32'h0);
		send_request(CMD_SEARCH, 16'd9, 32'h0);
		send_request(CMD_UNUSED, 16'h0000, 32'h1234_5678);
		send_request(CMD_DELETE, 16'd1234, 32'h0);
		// Fill every remaining slot, reusing the tombstone, then overflow.
		foreach (fill_keys[i])
			send_request(CMD_INSERT, fill_keys[i], $urandom());
		send_request(CMD_INSERT, 16'd11, 32'hDEAD_BEEF);
		// With no empty slot left, a miss must walk the whole probe sequence.
		send_request(CMD_SEARCH, 16'd20, 32'h0);
		send_request(CMD_DELETE, 16'h0000, 32'h0);

		for (int n = 0; n < ITEM_COUNT; n++) begin
			if (n == ITEM_COUNT - QUIET_ITEMS)
				quiet = 1'b1;
			if (n % 250 == 0)
				refill_pool();
			pick = $urandom_range(0, 99);
			// Phases of 120 requests lean toward inserts, then toward deletes,
			// so the table swings between nearly empty and full.
			if ((n / 120) % 2 == 0) begin
				if (pick < 55)
					op = CMD_INSERT;
				else if (pick < 75)
					op = CMD_SEARCH;
				else if (pick < 95)
					op = CMD_DELETE;
				else
					op = CMD_UNUSED;
			end else begin
				if (pick < 20)
					op = CMD_INSERT;
				else if (pick < 50)
					op = CMD_SEARCH;
				else if (pick < 95)
					op = CMD_DELETE;
				else
					op = CMD_UNUSED;
			end
			send_request(op, pick_key(), $urandom());
		end
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver: short random stall bursts, plus one long hold-off once traffic
	// is under way. During the hold-off the sender keeps offering requests,
	// so the block fills its response register and must stall its input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet) begin
				rsp_stall <= 1'b0;
			end else if (!held_long && requests_sent >= 300) begin
				held_long = 1'b1;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which neither channel moves anything.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule
